FILE: rtl/core/pbo_pkg.sv
package pbo_pkg;

	localparam int ROW_W = 10;
	localparam int SUM_W = 40;
	localparam int VAL_W = 32;

	typedef enum logic [1:0] {
		KIND_COEF = 2'd0,
		KIND_RHS  = 2'd1,
		KIND_OBJ  = 2'd2,
		KIND_EVAL = 2'd3
	} kind_t;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_RUN   = 5'b00100,
		ST_WAIT  = 5'b01000,
		ST_SPARE = 5'b10000
	} state_t;

	typedef struct packed {
		logic                    vld;
		logic                    is_obj;
		logic                    is_eq;
		logic [ROW_W-1:0]        row;
		logic signed [SUM_W-1:0] sum;
	} tok_t;

	typedef struct packed {
		logic             coef_en;
		logic             obj_en;
		logic             all;
		logic [5:0]       col;
		logic [ROW_W-1:0] addr;
		logic [VAL_W-1:0] data;
	} wr_t;

endpackage

FILE: rtl/core/pbo_ram.sv
module pbo_ram #(
	parameter int W = 32,
	parameter int D = 64
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0]                      wdata,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0]                      rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/core/pbo_cell.sv
module pbo_cell
	import pbo_pkg::*;
#(
	parameter int J        = 0,
	parameter int MAX_ROWS = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  wr_t  wr,
	input  logic x,
	input  tok_t tok_in,
	output tok_t tok_out
);
	localparam int AW = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;

	logic                    we;
	logic [VAL_W-1:0]        rdata;
	logic signed [VAL_W-1:0] obj_q;
	logic signed [VAL_W-1:0] term;
	tok_t                    tok_nxt;
	tok_t                    tok_s1;
	tok_t                    tok_s2;

	assign we = wr.coef_en && (wr.all || wr.col == 6'(J));

	pbo_ram #(.W(VAL_W), .D(MAX_ROWS)) u_col (
		.clk   (clk),
		.we    (we),
		.waddr (wr.addr[AW-1:0]),
		.wdata (wr.data),
		.raddr (tok_in.row[AW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obj_q <= '0;
		end else if (wr.obj_en && wr.col == 6'(J)) begin
			obj_q <= wr.data;
		end
	end

	always_comb begin
		term = tok_s1.is_obj ? obj_q : rdata;
		if (!x) begin
			term = '0;
		end
	end

	always_comb begin
		tok_nxt     = tok_s1;
		tok_nxt.sum = tok_s1.sum + {{(SUM_W-VAL_W){term[VAL_W-1]}}, term};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			tok_s2 <= '0;
		end else begin
			tok_s1 <= tok_in;
			tok_s2 <= tok_nxt;
		end
	end

	assign tok_out = tok_s2;
endmodule

FILE: rtl/core/pbo_constraint_evaluator.sv
// Pseudo-boolean constraint evaluator. Load items (tuser kind 0/1/2) write one
// coefficient, one rhs/row type or one objective coefficient and leave the
// evaluator idle and ready. An evaluate item (kind 3) streams an objective token
// and then one token per active row through a chain of MAX_VARS cells, one cell
// per variable, each cell holding its coefficient column in a small RAM and
// registering the token in its tok_s1 and tok_s2 registers. One token enters per
// cycle; the next item is accepted once the evaluation finishes, while the result
// may still wait at the output register. After reset a clearing pass over all
// MAX_ROWS rows zeroes the stores; items are not accepted until it ends.
module pbo_constraint_evaluator
	import pbo_pkg::*;
#(
	parameter int MAX_ROWS = 64,
	parameter int MAX_VARS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// row[5:0] col[11:6] value[43:12] is_equality[44] assignment[108:45]
	input  logic [111:0] s_tdata,
	// kind[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// feasible[0] satisfied_count[7:1] objective[46:8]
	output logic [47:0]  m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	localparam int AW = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
	localparam int IW = $clog2(MAX_ROWS + 1) > 0 ? $clog2(MAX_ROWS + 1) : 1;
	localparam int RW = $clog2(MAX_ROWS + 2);

	state_t              state_q;
	logic [6:0]          rows_q;
	logic [AW-1:0]       clr_q;
	logic [IW-1:0]       idx_q;
	logic [IW-1:0]       act_q;
	logic [IW-1:0]       cnt_q;
	logic [RW-1:0]       rcv_q;
	logic [63:0]         x_q;
	logic [38:0]         obj_q;
	tok_t                head_q;
	logic                out_vld_q;
	logic [47:0]         out_q;

	kind_t               kind;
	logic [5:0]          row;
	logic [5:0]          col;
	logic [31:0]         value;
	logic                is_eq;
	logic [63:0]         asg;
	logic [15:0]         row_w;
	logic                acc;
	logic                row_ok;
	logic                col_ok;
	logic                rhs_we;
	logic [AW-1:0]       rhs_waddr;
	logic [32:0]         rhs_wdata;
	logic [32:0]         rhs_rdata;
	logic [IW-1:0]       act_n;
	logic                done;
	logic                t_ok;
	wr_t                 wr;
	tok_t                tok [MAX_VARS+1];

	assign kind   = kind_t'(s_tuser);
	assign row    = s_tdata[5:0];
	assign col    = s_tdata[11:6];
	assign value  = s_tdata[43:12];
	assign is_eq  = s_tdata[44];
	assign asg    = s_tdata[108:45];
	assign row_w  = 16'(row);
	assign row_ok = row_w < 16'(MAX_ROWS);
	assign col_ok = 16'(col) < 16'(MAX_VARS);

	assign s_tready = state_q == ST_IDLE;
	assign acc      = s_tvalid && s_tready;

	// config port
	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {25'd0, rows_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= '0;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			rows_q <= pwdata[6:0];
		end
	end

	assign act_n = (11'(rows_q) > 11'(MAX_ROWS)) ? IW'(MAX_ROWS) : IW'(rows_q);

	// store writes
	always_comb begin
		wr        = '0;
		rhs_we    = 1'b0;
		rhs_waddr = row_w[AW-1:0];
		rhs_wdata = {is_eq, value};
		if (state_q == ST_CLEAR) begin
			wr.coef_en = 1'b1;
			wr.all     = 1'b1;
			wr.addr    = ROW_W'(clr_q);
			rhs_we     = 1'b1;
			rhs_waddr  = clr_q;
			rhs_wdata  = '0;
		end else if (acc) begin
			wr.col  = col;
			wr.addr = ROW_W'(row);
			wr.data = value;
			case (kind)
				KIND_COEF: wr.coef_en = row_ok && col_ok;
				KIND_OBJ:  wr.obj_en  = col_ok;
				KIND_RHS:  rhs_we     = row_ok;
				default:   wr.coef_en = 1'b0;
			endcase
		end
	end

	pbo_ram #(.W(33), .D(MAX_ROWS)) u_rhs (
		.clk   (clk),
		.we    (rhs_we),
		.waddr (rhs_waddr),
		.wdata (rhs_wdata),
		.raddr (idx_q[AW-1:0]),
		.rdata (rhs_rdata)
	);

	// chain
	assign tok[0] = head_q;

	for (genvar j = 0; j < MAX_VARS; j++) begin : g_cell
		pbo_cell #(.J(j), .MAX_ROWS(MAX_ROWS)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr      (wr),
			.x       (x_q[j]),
			.tok_in  (tok[j]),
			.tok_out (tok[j+1])
		);
	end

	assign t_ok = tok[MAX_VARS].is_eq ? (tok[MAX_VARS].sum == '0) : !tok[MAX_VARS].sum[SUM_W-1];
	assign done = rcv_q == RW'(act_q) + RW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			idx_q     <= '0;
			act_q     <= '0;
			cnt_q     <= '0;
			rcv_q     <= '0;
			head_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			head_q.vld <= state_q == ST_RUN;
			if (state_q == ST_WAIT && done && (!out_vld_q || m_tready)) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			if (tok[MAX_VARS].vld) begin
				rcv_q <= rcv_q + RW'(1);
				if (!tok[MAX_VARS].is_obj && t_ok) begin
					cnt_q <= cnt_q + IW'(1);
				end
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAX_ROWS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc && kind == KIND_EVAL) begin
						act_q   <= act_n;
						idx_q   <= '0;
						cnt_q   <= '0;
						rcv_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (idx_q == '0) begin
						head_q.is_obj <= 1'b1;
						head_q.is_eq  <= 1'b0;
						head_q.row    <= '0;
						head_q.sum    <= '0;
					end else begin
						head_q.is_obj <= 1'b0;
						head_q.is_eq  <= rhs_rdata[32];
						head_q.row    <= ROW_W'(idx_q - IW'(1));
						head_q.sum    <= -{{(SUM_W-VAL_W){rhs_rdata[31]}}, rhs_rdata[31:0]};
					end
					idx_q <= idx_q + IW'(1);
					if (idx_q == act_q) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (done && (!out_vld_q || m_tready)) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc && kind == KIND_EVAL) begin
			x_q <= asg;
		end
		if (tok[MAX_VARS].vld && tok[MAX_VARS].is_obj) begin
			obj_q <= tok[MAX_VARS].sum[38:0];
		end
		if (state_q == ST_WAIT && done && (!out_vld_q || m_tready)) begin
			out_q <= {1'b0, obj_q, 7'(cnt_q), cnt_q == act_q};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

	a_rcv_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rcv_q <= RW'(act_q) + RW'(1))
		else $error("more tokens received than issued");

	a_tail_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tok[MAX_VARS].vld |-> (state_q == ST_RUN || state_q == ST_WAIT))
		else $error("chain token outside evaluation");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAIT && done && m_tvalid && !m_tready) |=> state_q == ST_WAIT)
		else $error("result loaded over pending result");

endmodule

FILE: bench/pbo_constraint_checker.sv
`timescale 1ns / 100ps

module pbo_constraint_checker
	import pbo_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [111:0] s_tdata,
	input  logic [1:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [47:0]  m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	input  logic         pready,
	output int           mismatches,
	output int           pending
);

	localparam int NROWS = 64;
	localparam int NVARS = 64;
	localparam logic [2:0] ADDR_ROWS_IN_USE = 3'd0;

	typedef struct packed {
		logic signed [38:0] objective;
		logic [6:0]        sat_count;
		logic              feasible;
	} verdict_t;

	logic signed [31:0] coef_mem [NROWS][NVARS];
	logic signed [31:0] rhs_mem [NROWS];
	logic               eq_mem [NROWS];
	logic signed [31:0] obj_mem [NVARS];
	logic [6:0]         rows_active;
	verdict_t           verdict_q [$];

	function automatic verdict_t evaluate(logic [63:0] asg);
		verdict_t v;
		int nact;
		int hits;
		longint lhs;
		longint dot;
		bit ok;
		nact = (rows_active > NROWS) ? NROWS : rows_active;
		hits = 0;
		for (int r = 0; r < nact; r++) begin
			lhs = 0;
			for (int j = 0; j < NVARS; j++)
				if (asg[j])
					lhs += longint'(coef_mem[r][j]);
			ok = eq_mem[r] ? (lhs == longint'(rhs_mem[r])) : (lhs >= longint'(rhs_mem[r]));
			if (ok)
				hits++;
		end
		dot = 0;
		for (int j = 0; j < NVARS; j++)
			if (asg[j])
				dot += longint'(obj_mem[j]);
		v.feasible  = (hits == nact);
		v.sat_count = hits[6:0];
		v.objective = dot[38:0];
		return v;
	endfunction

	assign pending = verdict_q.size();

	always @(posedge clk or negedge arst_n) begin
		logic [5:0]  row;
		logic [5:0]  col;
		logic [31:0] val;
		verdict_t    exp_v;
		verdict_t    got_v;
		if (!arst_n) begin
			for (int r = 0; r < NROWS; r++) begin
				rhs_mem[r] = '0;
				eq_mem[r]  = 1'b0;
				for (int j = 0; j < NVARS; j++)
					coef_mem[r][j] = '0;
			end
			for (int j = 0; j < NVARS; j++)
				obj_mem[j] = '0;
			rows_active = '0;
			verdict_q.delete();
			mismatches = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == ADDR_ROWS_IN_USE)
				rows_active = pwdata[6:0];
			if (m_tvalid && m_tready) begin
				got_v = m_tdata[46:0];
				if (verdict_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result %h", $realtime, m_tdata);
				end else begin
					exp_v = verdict_q.pop_front();
					if (got_v !== exp_v) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: feasible %b/%b count %0d/%0d objective %0d/%0d (exp/got)",
								$realtime, exp_v.feasible, got_v.feasible, exp_v.sat_count,
								got_v.sat_count, exp_v.objective, got_v.objective);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				row = s_tdata[5:0];
				col = s_tdata[11:6];
				val = s_tdata[43:12];
				case (kind_t'(s_tuser))
					KIND_COEF: coef_mem[row][col] = val;
					KIND_RHS: begin
						rhs_mem[row] = val;
						eq_mem[row]  = s_tdata[44];
					end
					KIND_OBJ:  obj_mem[col] = val;
					KIND_EVAL: verdict_q.push_back(evaluate(s_tdata[108:45]));
				endcase
			end
		end
	end

	final begin
	end

endmodule

FILE: bench/tb_pbo_constraint_evaluator.sv
`timescale 1ns / 100ps

module tb_pbo_constraint_evaluator;
	import pbo_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE = 300;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [111:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [47:0]  m_tdata;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [2:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	int mismatches;
	int pending;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_left;
	bit hold_go;
	int quiet_cycles;

	pbo_constraint_evaluator i_dut (.*);

	pbo_constraint_checker i_checker (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_tdata(s_tdata), .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.m_tdata(m_tdata), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .pready(pready),
		.mismatches(mismatches), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (hold_go) begin
			hold_go = 1'b0;
			hold_left = 600;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send(kind_t kind, logic [5:0] row, logic [5:0] col, logic [31:0] val,
			logic is_eq, logic [63:0] asg);
		bit acc;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {3'b000, asg, is_eq, val, col, row};
		do begin
			#1;
			acc = s_tready;
			@(negedge clk);
		end while (!acc);
	endtask

	task automatic write_rows(logic [6:0] n);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		paddr   <= 3'd0;
		pwdata  <= {25'd0, n};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return $urandom;
			1:       return {$urandom_range(0, 1) ? 1'b1 : 1'b0, {31{$urandom_range(0, 1) == 1}}};
			default: return 32'($signed($urandom_range(0, 6)) - 3);
		endcase
	endfunction

	function automatic logic [63:0] pick_assignment();
		case ($urandom_range(0, 3))
			0:       return {$urandom, $urandom};
			1:       return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
			2:       return 64'd1 << $urandom_range(0, 63);
			default: return {$urandom, $urandom} & {$urandom, $urandom};
		endcase
	endfunction

	task automatic random_item(int max_row);
		logic [5:0] row;
		logic [5:0] col;
		row = $urandom_range(0, 9) == 0 ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, max_row));
		col = 6'($urandom_range(0, 63));
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5, 6, 7, 8:
				send(KIND_COEF, row, col, pick_value(), 1'($urandom), {$urandom, $urandom});
			9, 10, 11:
				send(KIND_RHS, row, col, pick_value(), 1'($urandom), {$urandom, $urandom});
			12, 13:
				send(KIND_OBJ, row, col, pick_value(), 1'($urandom), {$urandom, $urandom});
			default:
				send(KIND_EVAL, row, col, $urandom, 1'($urandom), pick_assignment());
		endcase
	endtask

	initial begin
		logic [6:0] rows_list [6];
		rows_list = '{7'd1, 7'd64, 7'd127, 7'd5, 7'd100, 7'd0};
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = KIND_COEF;
		m_tready = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		send_idle_pct = 10;
		recv_idle_pct = 67;
		hold_left = 0;
		hold_go = 1'b0;
		quiet_cycles = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// no active rows, then small system with extremes
		send(KIND_OBJ, 6'd0, 6'd63, 32'h7FFF_FFFF, 1'b0, '0);
		send(KIND_EVAL, 6'd0, 6'd0, '0, 1'b0, {64{1'b1}});
		write_rows(7'd3);
		send(KIND_COEF, 6'd0, 6'd0, 32'h7FFF_FFFF, 1'b0, '0);
		send(KIND_COEF, 6'd0, 6'd63, 32'h8000_0000, 1'b0, '0);
		send(KIND_COEF, 6'd1, 6'd1, 32'd5, 1'b0, '0);
		send(KIND_COEF, 6'd63, 6'd63, 32'hFFFF_FFFF, 1'b0, '0);
		send(KIND_RHS, 6'd0, 6'd0, 32'hFFFF_FFFF, 1'b1, '0);
		send(KIND_RHS, 6'd1, 6'd0, 32'd5, 1'b0, '0);
		send(KIND_RHS, 6'd2, 6'd0, 32'h8000_0000, 1'b0, '0);
		send(KIND_RHS, 6'd63, 6'd0, 32'h7FFF_FFFF, 1'b1, '0);
		send(KIND_OBJ, 6'd0, 6'd0, 32'h8000_0000, 1'b0, '0);
		send(KIND_OBJ, 6'd0, 6'd1, 32'h8000_0000, 1'b0, '0);
		send(KIND_EVAL, 6'd63, 6'd63, 32'hFFFF_FFFF, 1'b1, '0);
		send(KIND_EVAL, 6'd0, 6'd0, '0, 1'b0, {64{1'b1}});
		send(KIND_EVAL, 6'd0, 6'd0, '0, 1'b0, 64'h8000_0000_0000_0003);
		send(KIND_EVAL, 6'd0, 6'd0, '0, 1'b0, 64'hAAAA_AAAA_AAAA_AAAA);
		send(KIND_EVAL, 6'd0, 6'd0, '0, 1'b0, 64'h5555_5555_5555_5555);
		write_rows(7'd127);
		send(KIND_EVAL, 6'd0, 6'd0, '0, 1'b0, 64'h8000_0000_0000_0001);
		write_rows(7'd64);
		send(KIND_EVAL, 6'd0, 6'd0, '0, 1'b0, 64'h0000_0000_0000_0002);

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 67 : 0;
			recv_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 10 : 0;
			for (int blk = 0; blk < 3; blk++) begin
				write_rows(rows_list[(phase * 3 + blk) % 6]);
				for (int k = 0; k < 104; k++) begin
					if (phase == 2 && blk == 1 && k == 20)
						hold_go = 1'b1;
					random_item((blk == 2) ? 63 : 7);
				end
			end
		end
		s_tvalid <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/pbo_pkg.sv
rtl/core/pbo_ram.sv
rtl/core/pbo_cell.sv
rtl/core/pbo_constraint_evaluator.sv
bench/pbo_constraint_checker.sv
bench/tb_pbo_constraint_evaluator.sv
